// File: hdl/lge_pkg.sv
// Shared constants, types and helpers of the 5x5 LoG edge filter.
package lge_pkg;

	localparam int PIX_W       = 8;
	localparam int DIM_W       = 11;
	localparam int LEAD_W      = 13;
	localparam int RESP_W      = 13;
	localparam int MAX_W       = 12;
	localparam int TAP_W       = 6;
	localparam int WIN         = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 1024;
	localparam int DIM_RESET   = 256;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

	typedef logic signed [TAP_W-1:0] tap_t;
	typedef logic signed [RESP_W-1:0] resp_t;

	localparam tap_t LOG_TAPS [WIN][WIN] = '{
		'{ 6'sd0,  6'sd0, -6'sd1,  6'sd0,  6'sd0},
		'{ 6'sd0, -6'sd1, -6'sd2, -6'sd1,  6'sd0},
		'{-6'sd1, -6'sd2, 6'sd16, -6'sd2, -6'sd1},
		'{ 6'sd0, -6'sd1, -6'sd2, -6'sd1,  6'sd0},
		'{ 6'sd0,  6'sd0, -6'sd1,  6'sd0,  6'sd0}
	};

	// one item as it moves down the pipeline
	typedef struct packed {
		logic             write;
		logic             produce;
		logic             border;
		logic             last;
		logic [PIX_W-1:0] sample;
	} lge_item_t;

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int top);
		if (v == '0)
			return DIM_W'(1);
		if (int'(v) > top)
			return DIM_W'(top);
		return v;
	endfunction

	function automatic resp_t tap_mul(tap_t t, logic [PIX_W-1:0] p);
		resp_t ts;
		resp_t ps;
		ts = RESP_W'(t);
		ps = signed'({{(RESP_W-PIX_W){1'b0}}, p});
		return ts * ps;
	endfunction

endpackage

// File: hdl/lge_ctrl.sv
// Frame cursors, lead-in count and configuration registers.
module lge_ctrl #(
	parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lge_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          acc,
	input  logic [lge_pkg::PIX_W-1:0]     sample,
	input  logic                          drain,
	output lge_pkg::lge_item_t            item,
	output logic [$clog2(MAX_COLS)-1:0]   rd_addr,
	output logic                          restart
);
	import lge_pkg::*;

	localparam int AW = $clog2(MAX_COLS);
	localparam int EW = DIM_W + 1;
	localparam logic [DIM_W-1:0] ROWS_RST =
		DIM_W'((DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET);
	localparam logic [DIM_W-1:0] COLS_RST =
		DIM_W'((DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET);

	logic [DIM_W-1:0]  rows_q, cols_q;
	logic [DIM_W-1:0]  in_row_q, in_col_q;
	logic [DIM_W-1:0]  out_r_q, out_c_q;
	logic [LEAD_W-1:0] lead_q;
	logic              primed_q;

	logic              pending, bubble, wr, prod;
	logic              in_col_end, out_col_end, out_row_end, edge_hit;
	logic [LEAD_W-1:0] lag;

	assign pending = in_row_q < rows_q;
	assign bubble  = pending && drain;
	assign wr      = !bubble && pending;
	assign prod    = !bubble && primed_q;
	assign lag     = LEAD_W'({cols_q, 1'b0}) + LEAD_W'(2);

	assign in_col_end  = in_col_q == cols_q - DIM_W'(1);
	assign out_col_end = out_c_q == cols_q - DIM_W'(1);
	assign out_row_end = out_r_q == rows_q - DIM_W'(1);
	assign edge_hit    = (out_r_q < DIM_W'(2)) || (out_c_q < DIM_W'(2)) ||
		(EW'(out_r_q) + EW'(2) >= EW'(rows_q)) ||
		(EW'(out_c_q) + EW'(2) >= EW'(cols_q));

	assign item.write   = wr;
	assign item.produce = prod;
	assign item.border  = prod && edge_hit;
	assign item.last    = prod && out_row_end && out_col_end;
	assign item.sample  = sample;
	assign rd_addr      = AW'(in_col_q);

	assign restart = cfg_we && (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RST;
			cols_q   <= COLS_RST;
			in_row_q <= '0;
			in_col_q <= '0;
			out_r_q  <= '0;
			out_c_q  <= '0;
			lead_q   <= '0;
			primed_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_ROWS: rows_q <= clamp_dim(cfg_data, MAX_ROWS);
					REG_FRAME_COLS: cols_q <= clamp_dim(cfg_data, MAX_COLS);
					default: ;
				endcase
			end
			if (restart || (acc && item.last)) begin
				in_row_q <= '0;
				in_col_q <= '0;
				out_r_q  <= '0;
				out_c_q  <= '0;
				lead_q   <= '0;
				primed_q <= 1'b0;
			end else if (acc) begin
				if (wr) begin
					if (in_col_end) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + DIM_W'(1);
					end else begin
						in_col_q <= in_col_q + DIM_W'(1);
					end
				end
				if (prod) begin
					if (out_col_end) begin
						out_c_q <= '0;
						out_r_q <= out_r_q + DIM_W'(1);
					end else begin
						out_c_q <= out_c_q + DIM_W'(1);
					end
				end else if (!bubble) begin
					lead_q <= lead_q + LEAD_W'(1);
					if (lead_q + LEAD_W'(1) >= lag)
						primed_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/lge_line_mem.sv
// Line store: per column the four rows above, read-modify-write per sample.
module lge_line_mem #(
	parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [$clog2(MAX_COLS)-1:0]          rd_addr,
	input  logic                                 wr_en,
	input  logic [lge_pkg::PIX_W-1:0]            wr_sample,
	output logic [lge_pkg::WIN*lge_pkg::PIX_W-1:0] column
);
	import lge_pkg::*;

	localparam int AW = $clog2(MAX_COLS);
	localparam int MW = (WIN - 1) * PIX_W;

	logic [MW-1:0] mem [MAX_COLS];
	logic [MW-1:0] rd_q;
	logic [AW-1:0] addr_s1;

	// oldest row in the top byte; the same column comes back within one beat
	// only for frames narrower than five, which are border everywhere
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_en)
				mem[addr_s1] <= {rd_q[MW-PIX_W-1:0], wr_sample};
			rd_q    <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	assign column = {rd_q, wr_sample};

endmodule

// File: hdl/lge_conv.sv
// 5x5 window registers and the pipelined LoG sum.
module lge_conv (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   acc,
	input  lge_pkg::lge_item_t                     item,
	input  logic [lge_pkg::WIN*lge_pkg::PIX_W-1:0] column,
	output logic                                   wr_en,
	output logic [lge_pkg::PIX_W-1:0]              wr_sample,
	output logic                                   v_s4,
	output lge_pkg::lge_item_t                     item_s4,
	output lge_pkg::resp_t                         resp_s4
);
	import lge_pkg::*;

	logic      v_s1, v_s2, v_s3;
	lge_item_t item_s1, item_s2, item_s3;
	logic [PIX_W-1:0] win [WIN][WIN];
	resp_t     rsum [WIN];
	resp_t     rowsum_s3 [WIN];
	resp_t     tot;

	assign wr_en     = v_s1 && item_s1.write;
	assign wr_sample = item_s1.sample;

	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			rsum[i] = '0;
			for (int j = 0; j < WIN; j++)
				rsum[i] = rsum[i] + tap_mul(LOG_TAPS[i][j], win[i][j]);
		end
	end

	assign tot = rowsum_s3[0] + rowsum_s3[1] + rowsum_s3[2] + rowsum_s3[3] + rowsum_s3[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			// new column enters on the right, row 0 is the oldest line
			if (wr_en) begin
				for (int i = 0; i < WIN; i++) begin
					for (int j = 0; j < WIN - 1; j++)
						win[i][j] <= win[i][j+1];
					win[i][WIN-1] <= column[(WIN-1-i)*PIX_W +: PIX_W];
				end
			end
			for (int i = 0; i < WIN; i++)
				rowsum_s3[i] <= rsum[i];
			resp_s4 <= (item_s3.produce && !item_s3.border) ? tot : '0;
		end
	end

endmodule

// File: hdl/lge_stats.sv
// Running min/max per frame and the result register.
module lge_stats (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               restart,
	input  logic                               v_s4,
	input  lge_pkg::lge_item_t                 item_s4,
	input  lge_pkg::resp_t                     resp_s4,
	output logic                               res_valid,
	output logic                               out_valid,
	output logic signed [lge_pkg::RESP_W-1:0]  response,
	output logic                               on_border,
	output logic signed [lge_pkg::RESP_W-1:0]  min_so_far,
	output logic [lge_pkg::MAX_W-1:0]          max_so_far,
	output logic                               last_of_frame
);
	import lge_pkg::*;

	resp_t min_q, max_q, new_min, new_max;
	logic  res_valid_q, out_valid_q, on_border_q, last_q;
	resp_t response_q, min_out_q;
	logic [MAX_W-1:0] max_out_q;

	assign new_min = (item_s4.produce && resp_s4 < min_q) ? resp_s4 : min_q;
	assign new_max = (item_s4.produce && resp_s4 > max_q) ? resp_s4 : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			min_q       <= '0;
			max_q       <= '0;
		end else begin
			if (restart) begin
				min_q <= '0;
				max_q <= '0;
			end else if (en && v_s4) begin
				if (item_s4.last) begin
					min_q <= '0;
					max_q <= '0;
				end else begin
					min_q <= new_min;
					max_q <= new_max;
				end
			end
			if (en)
				res_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s4) begin
			out_valid_q <= item_s4.produce;
			response_q  <= resp_s4;
			on_border_q <= item_s4.border;
			last_q      <= item_s4.last;
			min_out_q   <= new_min;
			max_out_q   <= new_max[MAX_W-1:0];
		end
	end

	assign res_valid     = res_valid_q;
	assign out_valid     = out_valid_q;
	assign response      = response_q;
	assign on_border     = on_border_q;
	assign min_so_far    = min_out_q;
	assign max_so_far    = max_out_q;
	assign last_of_frame = last_q;

endmodule

// File: hdl/log_5x5_edge_filter.sv
// 5x5 Laplacian-of-Gaussian edge filter, top level.
// A result beat passes stages s1 to s4 and then the result register after its input beat is accepted.
// Throughput: one beat per cycle unless stalled; the line store takes one read and one write per cycle.
// The whole pipeline holds while the result register is full and not taken.
// Reset clears cursors, running min/max, res_valid and stage valid bits at once; no clearing pass:
// the line store is only read for windows written in the current frame.
module log_5x5_edge_filter #(
	parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lge_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lge_pkg::DIM_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lge_pkg::PIX_W-1:0]          sample,
	input  logic                               drain,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic                               out_valid,
	output logic signed [lge_pkg::RESP_W-1:0]  response,
	output logic                               on_border,
	output logic signed [lge_pkg::RESP_W-1:0]  min_so_far,
	output logic [lge_pkg::MAX_W-1:0]          max_so_far,
	output logic                               last_of_frame
);
	import lge_pkg::*;

	localparam int AW = $clog2(MAX_COLS);

	logic                   en, acc, restart;
	lge_item_t              item, item_s4;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en, v_s4;
	logic [PIX_W-1:0]       wr_sample;
	logic [WIN*PIX_W-1:0]   column;
	resp_t                  resp_s4;

	assign en        = !res_valid || res_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign acc       = in_valid && in_ready;

	lge_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.sample    (sample),
		.drain     (drain),
		.item      (item),
		.rd_addr   (rd_addr),
		.restart   (restart)
	);

	lge_line_mem #(
		.MAX_COLS (MAX_COLS)
	) u_mem (
		.clk       (clk),
		.en        (en),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_sample (wr_sample),
		.column    (column)
	);

	lge_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.acc       (acc),
		.item      (item),
		.column    (column),
		.wr_en     (wr_en),
		.wr_sample (wr_sample),
		.v_s4      (v_s4),
		.item_s4   (item_s4),
		.resp_s4   (resp_s4)
	);

	lge_stats u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.restart       (restart),
		.v_s4          (v_s4),
		.item_s4       (item_s4),
		.resp_s4       (resp_s4),
		.res_valid     (res_valid),
		.out_valid     (out_valid),
		.response      (response),
		.on_border     (on_border),
		.min_so_far    (min_so_far),
		.max_so_far    (max_so_far),
		.last_of_frame (last_of_frame)
	);

endmodule

// File: hdl/lge_checker.sv
// Port-level checks of the edge filter, bound to the top level.
module lge_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic                               out_valid,
	input logic signed [lge_pkg::RESP_W-1:0]  response,
	input logic                               on_border,
	input logic signed [lge_pkg::RESP_W-1:0]  min_so_far,
	input logic [lge_pkg::MAX_W-1:0]          max_so_far,
	input logic                               last_of_frame
);
	import lge_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(response) &&
		$stable(min_so_far) && $stable(last_of_frame))
		else $error("result beat changed while stalled");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> response == '0 && !on_border && !last_of_frame)
		else $error("empty beat carries response fields");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && on_border |-> response == '0 && out_valid)
		else $error("border beat with nonzero response");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |->
		$signed(min_so_far) <= $signed(response) &&
		$signed(response) <= $signed({1'b0, max_so_far}))
		else $error("response outside running min/max");

endmodule

bind log_5x5_edge_filter lge_checker u_lge_checker (.*);

// File: sim/tb_log_5x5_edge_filter.sv
// Self-checking testbench for the 5x5 LoG edge filter: stream driver, response checker, run control.
module tb_log_5x5_edge_filter;
	import lge_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int LAP_MASK [WIN][WIN] = '{
		'{ 0,  0, -1,  0,  0},
		'{ 0, -1, -2, -1,  0},
		'{-1, -2, 16, -2, -1},
		'{ 0, -1, -2, -1,  0},
		'{ 0,  0, -1,  0,  0}
	};

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             is_drain;
	} pixel_beat_t;

	typedef struct {
		logic                     out_valid;
		logic signed [RESP_W-1:0] response;
		logic                     on_border;
		logic signed [RESP_W-1:0] min_so_far;
		logic [MAX_W-1:0]         max_so_far;
		logic                     last_of_frame;
	} log_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     sample = '0;
	logic                 drain = 1'b0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic                 out_valid;
	logic signed [RESP_W-1:0] response;
	logic                 on_border;
	logic signed [RESP_W-1:0] min_so_far;
	logic [MAX_W-1:0]     max_so_far;
	logic                 last_of_frame;

	pixel_beat_t pixel_q [$];
	log_result_t due_responses [$];
	log_result_t head;
	int unsigned queued = 0;
	int unsigned accepted = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;

	// filter state as the block should hold it
	logic [PIX_W-1:0] rows_buf [WIN][DEF_MAX_COLS];
	int unsigned n_rows, n_cols, wr_row, wr_col, rd_pos, lead;
	logic primed;
	int run_min, run_max;

	log_5x5_edge_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .drain(drain),
		.res_valid(res_valid), .res_ready(res_ready),
		.out_valid(out_valid), .response(response), .on_border(on_border),
		.min_so_far(min_so_far), .max_so_far(max_so_far), .last_of_frame(last_of_frame)
	);

	always #10 clk = ~clk;

	function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned top);
		if (v == '0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic void restart_frame();
		wr_row = 0;
		wr_col = 0;
		rd_pos = 0;
		lead = 0;
		primed = 1'b0;
		run_min = 0;
		run_max = 0;
	endfunction

	function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		if (idx == REG_FRAME_ROWS) begin
			n_rows = fit_dim(val, DEF_MAX_ROWS);
			restart_frame();
		end else if (idx == REG_FRAME_COLS) begin
			n_cols = fit_dim(val, DEF_MAX_COLS);
			restart_frame();
		end
	endfunction

	// one accepted beat -> the response beat it causes
	function automatic void advance_filter(logic [PIX_W-1:0] pix, logic drn);
		log_result_t res;
		int unsigned rr, cc, i, j;
		int acc;
		logic pending;
		res = '{default: '0};
		acc = 0;
		pending = (wr_row < n_rows);
		if (!(pending && drn)) begin
			if (pending) begin
				rows_buf[wr_row % WIN][wr_col] = pix;
				wr_col++;
				if (wr_col >= n_cols) begin
					wr_col = 0;
					wr_row++;
				end
			end
			if (primed) begin
				rr = rd_pos / n_cols;
				cc = rd_pos % n_cols;
				res.out_valid = 1'b1;
				if (rr < 2 || rr + 2 >= n_rows || cc < 2 || cc + 2 >= n_cols) begin
					res.on_border = 1'b1;
				end else begin
					for (i = 0; i < WIN; i++)
						for (j = 0; j < WIN; j++)
							acc += LAP_MASK[i][j] * int'(rows_buf[(rr + i - 2) % WIN][cc + j - 2]);
				end
				res.response = RESP_W'(acc);
				if (acc > run_max)
					run_max = acc;
				if (acc < run_min)
					run_min = acc;
				rd_pos++;
				if (rd_pos >= n_rows * n_cols)
					res.last_of_frame = 1'b1;
			end else begin
				lead++;
				if (lead >= 2 * n_cols + 2)
					primed = 1'b1;
			end
		end
		res.min_so_far = RESP_W'(run_min);
		res.max_so_far = MAX_W'(run_max);
		due_responses.push_back(res);
		if (res.last_of_frame)
			restart_frame();
	endfunction

	function automatic void check_field(string name, logic signed [15:0] want,
			logic signed [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	function automatic void add_beat(logic [PIX_W-1:0] val, logic drn);
		pixel_q.push_back('{value: val, is_drain: drn});
		queued++;
	endfunction

	task automatic settle();
		do @(posedge clk); while (accepted != queued || due_responses.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_register(idx, val);
	endtask

	// frame: all pixels, then enough tail beats to flush it, unless cut stops it early
	task automatic queue_frame(int unsigned rows, int unsigned cols, int unsigned bubble_pct,
			int unsigned cut);
		int unsigned total, style;
		logic [PIX_W-1:0] px;
		total = rows * cols;
		style = $urandom_range(3, 0);
		for (int unsigned p = 0; p < total + 2 * cols + 2; p++) begin
			if (cut != 0 && p >= cut)
				break;
			if (p < total) begin
				if ($urandom_range(99, 0) < bubble_pct)
					add_beat(PIX_W'($urandom_range(255, 0)), 1'b1);
				case (style)
					0: px = PIX_W'($urandom_range(255, 0));
					1: px = $urandom_range(1, 0) ? 8'hFF : 8'h00;
					2: px = PIX_W'($urandom_range(3, 0));
					default: px = 8'hFF - PIX_W'($urandom_range(3, 0));
				endcase
				add_beat(px, 1'b0);
			end else begin
				// most samples in the tail are marked as drains; an occasional one is not
				add_beat(PIX_W'($urandom_range(255, 0)), $urandom_range(7, 0) != 0);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
				in_valid <= 1'b1;
				sample <= pixel_q[0].value;
				drain <= pixel_q[0].is_drain;
				void'(pixel_q.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ready <= 1'b0;
		else
			res_ready <= ($urandom_range(99, 0) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (due_responses.size() == 0) begin
					errors++;
					$display("%0t: response beat expected none, got response %0d",
						$time, response);
				end else begin
					head = due_responses.pop_front();
					check_field("out_valid", head.out_valid, out_valid);
					check_field("response", head.response, response);
					check_field("on_border", head.on_border, on_border);
					check_field("min_so_far", head.min_so_far, min_so_far);
					check_field("max_so_far", head.max_so_far, max_so_far);
					check_field("last_of_frame", head.last_of_frame, last_of_frame);
				end
			end
			if (in_valid && in_ready) begin
				accepted++;
				advance_filter(sample, drain);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned p, r, c, d, rows, cols, er, ec, len, nfr, cut, ph, fed;
		n_rows = DIM_RESET;
		n_cols = DIM_RESET;
		for (r = 0; r < WIN; r++)
			for (c = 0; c < DEF_MAX_COLS; c++)
				rows_buf[r][c] = '0;
		restart_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// 5x10 frame: a lone bright pixel gives the top response, a dark pixel
		// ringed by bright mask neighbors gives the bottom one
		write_reg(REG_FRAME_ROWS, DIM_W'(5));
		write_reg(REG_FRAME_COLS, DIM_W'(10));
		for (p = 0; p < 50; p++) begin
			r = p / 10;
			c = p % 10;
			d = (r > 2 ? r - 2 : 2 - r) + (c > 7 ? c - 7 : 7 - c);
			if (p == 25) begin
				// unused indexes must not restart the frame
				settle();
				write_reg(REG_SPARE_2, 11'h7FF);
				write_reg(REG_SPARE_3, 11'h003);
			end
			if (p == 3)
				add_beat(8'h5A, 1'b1);
			add_beat(((r == 2 && c == 2) || (d >= 1 && d <= 2)) ? 8'hFF : 8'h00, 1'b0);
		end
		for (p = 0; p < 22; p++)
			add_beat(PIX_W'($urandom_range(255, 0)), !(p == 5 || p == 11));
		settle();
		// zero sizes count as one: a 1x1 frame
		write_reg(REG_FRAME_ROWS, DIM_W'(0));
		write_reg(REG_FRAME_COLS, DIM_W'(0));
		for (p = 0; p < 5; p++)
			add_beat(p == 0 ? 8'hFF : 8'h00, p != 0);
		settle();

		ph = 0;
		fed = 0;
		while (fed < 1450) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 56; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 56; end
				default: begin send_idle = 9; recv_stall = 9; end
			endcase
			if (ph == 3) begin
				write_reg(REG_FRAME_ROWS, 11'h7FF);
				write_reg(REG_FRAME_COLS, DIM_W'(1));
				queue_frame(DEF_MAX_ROWS, 1, 5, 0);
				fed += DEF_MAX_ROWS + 4;
			end else if (ph == 6) begin
				// widest frame, only its start; the next write restarts it
				write_reg(REG_FRAME_ROWS, DIM_W'(1));
				write_reg(REG_FRAME_COLS, 11'h7FF);
				queue_frame(1, DEF_MAX_COLS, 5, 300);
				fed += 300;
			end else begin
				rows = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(9, 1);
				cols = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(12, 1);
				if ($urandom_range(9, 0) == 0)
					cols = $urandom_range(40, 13);
				write_reg(REG_FRAME_ROWS, DIM_W'(rows));
				write_reg(REG_FRAME_COLS, DIM_W'(cols));
				er = fit_dim(DIM_W'(rows), DEF_MAX_ROWS);
				ec = fit_dim(DIM_W'(cols), DEF_MAX_COLS);
				len = er * ec + 2 * ec + 2;
				nfr = $urandom_range(3, 1);
				for (int unsigned f = 0; f < nfr; f++) begin
					// sometimes the last frame is cut short; the next write restarts it
					cut = (f == nfr - 1 && $urandom_range(4, 0) == 0) ? $urandom_range(len - 1, 1) : 0;
					queue_frame(er, ec, $urandom_range(20, 0), cut);
					fed += (cut != 0) ? cut : len;
					if (ph % 5 == 4)
						settle();
				end
			end
			settle();
			ph++;
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
